@@ src/fsc_pkg.sv @@
package fsc_pkg;

  localparam int LaneW = 21;
  localparam int RadW  = 20;
  localparam int CoefW = 20;
  localparam int VecW  = 3 * LaneW;
  localparam int IdxW  = 3;

  localparam logic [RadW-1:0] NearReset = 20'd6;
  localparam logic [RadW-1:0] FarReset  = 20'd640000;

  typedef enum logic [IdxW-1:0] {
    REG_CAMERA_POSITION,
    REG_VIEW_DIRECTION,
    REG_UP_DIRECTION,
    REG_RIGHT_DIRECTION,
    REG_NEAR_PLANE,
    REG_FAR_PLANE,
    REG_TANGENT_ASPECT,
    REG_SPHERE_FACTORS
  } reg_index_t;

endpackage

@@ src/fsc_if.sv @@
interface fsc_sphere_if;
  logic                                valid;
  logic                                ready;
  logic signed [fsc_pkg::LaneW-1:0]    center_x;
  logic signed [fsc_pkg::LaneW-1:0]    center_y;
  logic signed [fsc_pkg::LaneW-1:0]    center_z;
  logic        [fsc_pkg::RadW-1:0]     radius;

  modport source(output valid, center_x, center_y, center_z, radius, input ready);
  modport sink(input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface fsc_result_if;
  logic valid;
  logic ready;
  logic culled;

  modport source(output valid, culled, input ready);
  modport sink(input valid, culled, output ready);
endinterface

@@ src/frustum_sphere_cull_unit.sv @@
// Sphere-versus-frustum culling, one bounding sphere per word.
// sphere channel: center_x/y/z (signed Q14.6) and radius (Q14.6) in.
// result channel: culled = 1 when the sphere lies outside the frustum.
// Both channels move a word at a rising edge with valid and ready high.
// Camera and frustum values are loaded through write_enable,
// register_index and write_data; the user must do so only while no
// sphere is in flight, as the block itself does not enforce it.
// A word enters the first of seven register stages when accepted
// (offset, products, dot sums, depth test and depth-times-tangent,
// vertical test and side terms, horizontal bound, final compare).
// Throughput: one sphere per cycle while result.ready stays high.
// Each stage advances when its successor is free, so bubbles close up
// and sphere.ready stays high until every stage holds a word while the
// receiver stalls; a stalled result holds with nothing lost.
// Reset clears all valid bits, sets near_plane to 6, far_plane to
// 640000 and every other configuration register to zero.
module frustum_sphere_cull_unit (
  input  logic                         clk,
  input  logic                         rst,
  fsc_sphere_if.sink                   sphere,
  fsc_result_if.source                 result,
  input  logic                         write_enable,
  input  logic [fsc_pkg::IdxW-1:0]     register_index,
  input  logic [fsc_pkg::VecW-1:0]     write_data
);

  logic [fsc_pkg::VecW-1:0]   camera_position;
  logic [fsc_pkg::VecW-1:0]   view_direction;
  logic [fsc_pkg::VecW-1:0]   up_direction;
  logic [fsc_pkg::VecW-1:0]   right_direction;
  logic [fsc_pkg::RadW-1:0]   near_plane;
  logic [fsc_pkg::RadW-1:0]   far_plane;
  logic [2*fsc_pkg::CoefW-1:0] tangent_and_aspect;
  logic [2*fsc_pkg::CoefW-1:0] sphere_factors;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_position    <= '0;
      view_direction     <= '0;
      up_direction       <= '0;
      right_direction    <= '0;
      near_plane         <= fsc_pkg::NearReset;
      far_plane          <= fsc_pkg::FarReset;
      tangent_and_aspect <= '0;
      sphere_factors     <= '0;
    end else if (write_enable) begin
      case (fsc_pkg::reg_index_t'(register_index))
        fsc_pkg::REG_CAMERA_POSITION: camera_position    <= write_data;
        fsc_pkg::REG_VIEW_DIRECTION:  view_direction     <= write_data;
        fsc_pkg::REG_UP_DIRECTION:    up_direction       <= write_data;
        fsc_pkg::REG_RIGHT_DIRECTION: right_direction    <= write_data;
        fsc_pkg::REG_NEAR_PLANE:      near_plane         <= write_data[19:0];
        fsc_pkg::REG_FAR_PLANE:       far_plane          <= write_data[19:0];
        fsc_pkg::REG_TANGENT_ASPECT:  tangent_and_aspect <= write_data[39:0];
        fsc_pkg::REG_SPHERE_FACTORS:  sphere_factors     <= write_data[39:0];
        default: ;
      endcase
    end
  end

  logic signed [20:0] cam [3];
  logic signed [20:0] vdir [3];
  logic signed [20:0] udir [3];
  logic signed [20:0] rdir [3];
  logic signed [20:0] ctr [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cam[k]  = camera_position[fsc_pkg::LaneW*k +: fsc_pkg::LaneW];
      vdir[k] = view_direction[fsc_pkg::LaneW*k +: fsc_pkg::LaneW];
      udir[k] = up_direction[fsc_pkg::LaneW*k +: fsc_pkg::LaneW];
      rdir[k] = right_direction[fsc_pkg::LaneW*k +: fsc_pkg::LaneW];
    end
    ctr[0] = sphere.center_x;
    ctr[1] = sphere.center_y;
    ctr[2] = sphere.center_z;
  end

  logic [7:1] vld;
  logic [7:1] en;

  always_comb begin
    en[7] = !vld[7] || result.ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= sphere.valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: offset from camera
  logic signed [21:0] s1_v [3];
  logic        [19:0] s1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_v[k] <= {ctr[k][20], ctr[k]} - {cam[k][20], cam[k]};
      end
      s1_r <= sphere.radius;
    end
  end

  // stage 2: axis products
  logic signed [42:0] s2_pz [3];
  logic signed [42:0] s2_py [3];
  logic signed [42:0] s2_px [3];
  logic        [39:0] s2_fxr;
  logic        [39:0] s2_fyr;
  logic        [19:0] s2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_pz[k] <= s1_v[k] * vdir[k];
        s2_py[k] <= s1_v[k] * udir[k];
        s2_px[k] <= s1_v[k] * rdir[k];
      end
      s2_fyr <= sphere_factors[19:0] * s1_r;
      s2_fxr <= sphere_factors[39:20] * s1_r;
      s2_r   <= s1_r;
    end
  end

  // stage 3: dot products and depth bounds
  logic signed [45:0] dot_z;
  logic signed [45:0] dot_y;
  logic signed [45:0] dot_x;

  always_comb begin
    dot_z = 46'(s2_pz[0]) + 46'(s2_pz[1]) + 46'(s2_pz[2]);
    dot_y = 46'(s2_py[0]) + 46'(s2_py[1]) + 46'(s2_py[2]);
    dot_x = 46'(s2_px[0]) + 46'(s2_px[1]) + 46'(s2_px[2]);
  end

  logic signed [45:0] s3_az;
  logic signed [45:0] s3_ay;
  logic signed [45:0] s3_ax;
  logic        [20:0] s3_hi_lim;
  logic signed [20:0] s3_lo_lim;
  logic        [39:0] s3_fxr;
  logic        [39:0] s3_fyr;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_az     <= -dot_z;
      s3_ay     <= dot_y;
      s3_ax     <= dot_x;
      s3_hi_lim <= {1'b0, far_plane} + {1'b0, s2_r};
      s3_lo_lim <= {1'b0, near_plane} - {1'b0, s2_r};
      s3_fxr    <= s2_fxr;
      s3_fyr    <= s2_fyr;
    end
  end

  // stage 4: depth test, depth times tangent
  logic signed [46:0] az_ext;
  logic signed [46:0] hi_bound;
  logic signed [46:0] lo_bound;
  logic signed [41:0] az_trim;
  logic signed [20:0] tan_s;

  always_comb begin
    az_ext   = {s3_az[45], s3_az};
    hi_bound = {7'b0, s3_hi_lim, 19'b0};
    lo_bound = {{7{s3_lo_lim[20]}}, s3_lo_lim, 19'b0};
    az_trim  = s3_az[41:0];
    tan_s    = {1'b0, tangent_and_aspect[19:0]};
  end

  logic               s4_depth_fail;
  logic signed [62:0] s4_az1;
  logic signed [45:0] s4_ay;
  logic signed [45:0] s4_ax;
  logic        [39:0] s4_fxr;
  logic        [39:0] s4_fyr;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_depth_fail <= (az_ext > hi_bound) || (az_ext < lo_bound);
      s4_az1        <= az_trim * tan_s;
      s4_ay         <= s3_ay;
      s4_ax         <= s3_ax;
      s4_fxr        <= s3_fxr;
      s4_fyr        <= s3_fyr;
    end
  end

  // stage 5: vertical test, split product for horizontal bound
  logic signed [63:0] ay_sh;
  logic signed [63:0] az1_ext;
  logic signed [63:0] dy;
  logic signed [63:0] vbound;
  logic signed [30:0] az1_hi;
  logic        [31:0] az1_lo;
  logic signed [20:0] ratio_s;
  logic signed [47:0] ax_ext;
  logic signed [47:0] dx;

  always_comb begin
    ay_sh   = {s4_ay[45], s4_ay[45], s4_ay, 16'b0};
    az1_ext = {s4_az1[62], s4_az1};
    dy      = {5'b0, s4_fyr, 19'b0};
    vbound  = az1_ext + dy;
    az1_hi  = s4_az1[62:32];
    az1_lo  = s4_az1[31:0];
    ratio_s = {1'b0, tangent_and_aspect[39:20]};
    ax_ext  = {s4_ax[45], s4_ax[45], s4_ax};
    dx      = {5'b0, s4_fxr, 3'b0};
  end

  logic               s5_fail;
  logic signed [51:0] s5_hr;
  logic        [51:0] s5_lr;
  logic signed [47:0] s5_dxa;
  logic signed [47:0] s5_dxb;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_fail <= s4_depth_fail || (ay_sh > vbound) || ((ay_sh + vbound) < 64'sd0);
      s5_hr   <= az1_hi * ratio_s;
      s5_lr   <= az1_lo * tangent_and_aspect[39:20];
      s5_dxa  <= ax_ext - dx;
      s5_dxb  <= -(ax_ext + dx);
    end
  end

  // stage 6: horizontal bound, floor of depth*tangent*ratio
  logic               s6_fail;
  logic signed [52:0] s6_h;
  logic signed [47:0] s6_dxa;
  logic signed [47:0] s6_dxb;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_fail <= s5_fail;
      s6_h    <= {s5_hr[51], s5_hr} + {33'b0, s5_lr[51:32]};
      s6_dxa  <= s5_dxa;
      s6_dxb  <= s5_dxb;
    end
  end

  // stage 7: horizontal test, output register
  logic signed [52:0] dxa_ext;
  logic signed [52:0] dxb_ext;
  logic               s7_culled;

  always_comb begin
    dxa_ext = {{5{s6_dxa[47]}}, s6_dxa};
    dxb_ext = {{5{s6_dxb[47]}}, s6_dxb};
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_culled <= s6_fail || (dxa_ext > s6_h) || (dxb_ext > s6_h);
    end
  end

  assign sphere.ready  = en[1];
  assign result.valid  = vld[7];
  assign result.culled = s7_culled;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !sphere.ready |-> (&vld))
    else $error("input blocked while a stage is empty");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && en[4]) |=> vld[4])
    else $error("word lost between depth stages");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[6] && !en[6]) |=> (vld[6] && $stable(s6_h) && $stable(s6_fail)))
    else $error("stalled stage changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

@@ dv/frustum_sphere_cull_checker.sv @@
`timescale 1ns / 1ps

module frustum_sphere_cull_checker (
  input  logic                     clk,
  input  logic                     rst,
  fsc_sphere_if                    sphere,
  fsc_result_if                    result,
  input  logic                     write_enable,
  input  logic [fsc_pkg::IdxW-1:0] register_index,
  input  logic [fsc_pkg::VecW-1:0] write_data,
  output int                       mismatches,
  output int                       pending,
  output int                       results_seen,
  output int                       culled_seen
);

  typedef logic signed [127:0] acc_t;

  logic [fsc_pkg::VecW-1:0]    cam_pos;
  logic [fsc_pkg::VecW-1:0]    view_dir;
  logic [fsc_pkg::VecW-1:0]    up_dir;
  logic [fsc_pkg::VecW-1:0]    right_dir;
  logic [fsc_pkg::RadW-1:0]    near_dist;
  logic [fsc_pkg::RadW-1:0]    far_dist;
  logic [2*fsc_pkg::CoefW-1:0] tan_aspect;
  logic [2*fsc_pkg::CoefW-1:0] factors;
  logic                        expected_culls[$];
  logic                        want;

  function automatic acc_t lane_at(logic [fsc_pkg::VecW-1:0] vec, int k);
    logic signed [fsc_pkg::LaneW-1:0] s;
    s = vec[fsc_pkg::LaneW*k +: fsc_pkg::LaneW];
    return s;
  endfunction

  function automatic acc_t project(acc_t ox, acc_t oy, acc_t oz,
                                   logic [fsc_pkg::VecW-1:0] axis);
    return ox * lane_at(axis, 0) + oy * lane_at(axis, 1) + oz * lane_at(axis, 2);
  endfunction

  function automatic logic sphere_outside(logic signed [fsc_pkg::LaneW-1:0] cx,
                                          logic signed [fsc_pkg::LaneW-1:0] cy,
                                          logic signed [fsc_pkg::LaneW-1:0] cz,
                                          logic [fsc_pkg::RadW-1:0] rad);
    acc_t ox, oy, oz, r, near_v, far_v, tanv, ratio, fy, fx;
    acc_t depth, depth_tan, up_off, up_margin, side_off, side_margin, side_bound;
    ox = cx;
    oy = cy;
    oz = cz;
    ox = ox - lane_at(cam_pos, 0);
    oy = oy - lane_at(cam_pos, 1);
    oz = oz - lane_at(cam_pos, 2);
    r = rad;
    near_v = near_dist;
    far_v = far_dist;
    tanv = tan_aspect[fsc_pkg::CoefW-1:0];
    ratio = tan_aspect[2*fsc_pkg::CoefW-1:fsc_pkg::CoefW];
    fy = factors[fsc_pkg::CoefW-1:0];
    fx = factors[2*fsc_pkg::CoefW-1:fsc_pkg::CoefW];

    depth = -project(ox, oy, oz, view_dir);
    if (depth > (far_v + r) * 524288 || depth < (near_v - r) * 524288) return 1'b1;

    up_off = project(ox, oy, oz, up_dir) * 65536;
    depth_tan = depth * tanv;
    up_margin = fy * r * 524288;
    if (up_off > depth_tan + up_margin || up_off < -depth_tan - up_margin) return 1'b1;

    side_bound = (depth_tan * ratio) >>> 32;
    side_off = project(ox, oy, oz, right_dir);
    side_margin = fx * r * 8;
    return (side_off - side_margin - side_bound >= 1) ||
           (side_off + side_margin + side_bound <= -1);
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cam_pos    = '0;
      view_dir   = '0;
      up_dir     = '0;
      right_dir  = '0;
      near_dist  = fsc_pkg::NearReset;
      far_dist   = fsc_pkg::FarReset;
      tan_aspect = '0;
      factors    = '0;
      expected_culls.delete();
      pending = 0;
    end else begin
      if (write_enable) begin
        case (fsc_pkg::reg_index_t'(register_index))
          fsc_pkg::REG_CAMERA_POSITION: cam_pos = write_data;
          fsc_pkg::REG_VIEW_DIRECTION:  view_dir = write_data;
          fsc_pkg::REG_UP_DIRECTION:    up_dir = write_data;
          fsc_pkg::REG_RIGHT_DIRECTION: right_dir = write_data;
          fsc_pkg::REG_NEAR_PLANE:      near_dist = write_data[fsc_pkg::RadW-1:0];
          fsc_pkg::REG_FAR_PLANE:       far_dist = write_data[fsc_pkg::RadW-1:0];
          fsc_pkg::REG_TANGENT_ASPECT:  tan_aspect = write_data[2*fsc_pkg::CoefW-1:0];
          fsc_pkg::REG_SPHERE_FACTORS:  factors = write_data[2*fsc_pkg::CoefW-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        results_seen++;
        if (result.culled === 1'b1) culled_seen++;
        if (expected_culls.size() == 0) begin
          note_failure($sformatf("unexpected result word at %0t: culled=%b",
                                 $realtime, result.culled));
        end else begin
          want = expected_culls.pop_front();
          if (result.culled !== want)
            note_failure($sformatf("culled mismatch on result %0d at %0t: expected %b, got %b",
                                   results_seen, $realtime, want, result.culled));
        end
      end
      if (sphere.valid && sphere.ready)
        expected_culls.push_back(sphere_outside(sphere.center_x, sphere.center_y,
                                                sphere.center_z, sphere.radius));
      pending = expected_culls.size();
    end
  end

endmodule

@@ dv/frustum_sphere_cull_unit_tb.sv @@
`timescale 1ns / 1ps

module frustum_sphere_cull_unit_tb;

  typedef logic [fsc_pkg::VecW-1:0] word_t;

  localparam longint LaneMax = 2**(fsc_pkg::LaneW-1) - 1;
  localparam longint LaneMin = -(2**(fsc_pkg::LaneW-1));
  localparam longint RadMax  = 2**fsc_pkg::RadW - 1;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      write_enable;
  logic [fsc_pkg::IdxW-1:0]  register_index;
  logic [fsc_pkg::VecW-1:0]  write_data;

  fsc_sphere_if sphere();
  fsc_result_if result();

  int     mismatches, pending, results_seen, culled_seen;
  int     items_sent, setups;
  bit     calm;
  bit     aimed;
  longint cam_l[3];
  int     fwd_s[3], up_s[3], right_s[3];
  longint near_l, far_l, tan_l, ratio_l, fy_l, fx_l;

  frustum_sphere_cull_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .sphere         (sphere),
    .result         (result),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  frustum_sphere_cull_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .sphere         (sphere),
    .result         (result),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen),
    .culled_seen    (culled_seen)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    result.ready <= calm || ($urandom_range(99) >= 22);
  end

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint pick_offset(longint b);
    if (b < 0) b = -b;
    if ($urandom_range(3) == 0) return ($urandom_range(1) ? b : -b) + pick(-1, 1);
    return pick(-(b + b / 4 + 2), b + b / 4 + 2);
  endfunction

  function automatic longint pick_radius();
    case ($urandom_range(9))
      6, 7: return $urandom_range(20000);
      8: return $urandom & RadMax;
      9: return $urandom_range(1) ? RadMax : 0;
      default: return $urandom_range(400);
    endcase
  endfunction

  function automatic word_t pack3(longint x, longint y, longint z);
    return {z[fsc_pkg::LaneW-1:0], y[fsc_pkg::LaneW-1:0], x[fsc_pkg::LaneW-1:0]};
  endfunction

  task automatic send_sphere(input longint x, input longint y, input longint z,
                             input longint r);
    while (!calm && $urandom_range(99) < 22) begin
      sphere.valid <= 1'b0;
      @(negedge clk);
    end
    sphere.valid    <= 1'b1;
    sphere.center_x <= x[fsc_pkg::LaneW-1:0];
    sphere.center_y <= y[fsc_pkg::LaneW-1:0];
    sphere.center_z <= z[fsc_pkg::LaneW-1:0];
    sphere.radius   <= r[fsc_pkg::RadW-1:0];
    @(posedge clk);
    while (!sphere.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    sphere.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic load_frustum(input word_t cam, input word_t view, input word_t up,
                              input word_t right, input word_t near_v, input word_t far_v,
                              input word_t tan_asp, input word_t fac);
    fsc_pkg::reg_index_t order[8];
    word_t               vals[8];
    int                  i;
    order = '{fsc_pkg::REG_CAMERA_POSITION, fsc_pkg::REG_VIEW_DIRECTION,
              fsc_pkg::REG_UP_DIRECTION, fsc_pkg::REG_RIGHT_DIRECTION,
              fsc_pkg::REG_NEAR_PLANE, fsc_pkg::REG_FAR_PLANE,
              fsc_pkg::REG_TANGENT_ASPECT, fsc_pkg::REG_SPHERE_FACTORS};
    vals = '{cam, view, up, right, near_v, far_v, tan_asp, fac};
    wait_for_results();
    for (i = 0; i < 8; i++) begin
      write_enable   <= 1'b1;
      register_index <= order[i];
      write_data     <= vals[i];
      @(negedge clk);
    end
    write_enable <= 1'b0;
    for (i = 0; i < 3; i++) cam_l[i] = $signed(cam[fsc_pkg::LaneW*i +: fsc_pkg::LaneW]);
    near_l  = near_v[fsc_pkg::RadW-1:0];
    far_l   = far_v[fsc_pkg::RadW-1:0];
    tan_l   = tan_asp[fsc_pkg::CoefW-1:0];
    ratio_l = tan_asp[2*fsc_pkg::CoefW-1:fsc_pkg::CoefW];
    fy_l    = fac[fsc_pkg::CoefW-1:0];
    fx_l    = fac[2*fsc_pkg::CoefW-1:fsc_pkg::CoefW];
    aimed   = 1'b0;
    setups++;
  endtask

  task automatic set_frustum(input longint px, input longint py, input longint pz,
                             input int fa, input int fs, input int ua, input int us,
                             input int ra, input int rs, input longint scale,
                             input longint near_v, input longint far_v,
                             input longint tanv, input longint ratio,
                             input longint fy, input longint fx);
    longint vw[3], uw[3], rw[3];
    vw = '{0, 0, 0};
    uw = '{0, 0, 0};
    rw = '{0, 0, 0};
    vw[fa] = -fs * scale;
    uw[ua] = us * scale;
    rw[ra] = rs * scale;
    load_frustum(pack3(px, py, pz), pack3(vw[0], vw[1], vw[2]),
                 pack3(uw[0], uw[1], uw[2]), pack3(rw[0], rw[1], rw[2]),
                 word_t'(near_v), word_t'(far_v),
                 word_t'((ratio << fsc_pkg::CoefW) | tanv),
                 word_t'((fx << fsc_pkg::CoefW) | fy));
    fwd_s   = '{0, 0, 0};
    up_s    = '{0, 0, 0};
    right_s = '{0, 0, 0};
    fwd_s[fa]   = fs;
    up_s[ua]    = us;
    right_s[ra] = rs;
    aimed = 1'b1;
  endtask

  task automatic send_aimed();
    longint r, d, lo_d, hi_d, t, yy, xx, c[3];
    int     k;
    r = pick_radius();
    lo_d = near_l - r;
    hi_d = far_l + r;
    if (lo_d > hi_d) begin
      t = lo_d;
      lo_d = hi_d;
      hi_d = t;
    end
    case ($urandom_range(9))
      0: d = near_l - r + pick(-1, 1);
      1: d = far_l + r + pick(-1, 1);
      2: d = pick(lo_d - 3000, lo_d);
      default: d = pick(lo_d, hi_d);
    endcase
    yy = pick_offset(((d * tan_l) >>> 16) + ((fy_l * r) >>> 16));
    xx = pick_offset(((((d * tan_l) >>> 16) * ratio_l) >>> 16) + ((fx_l * r) >>> 16));
    for (k = 0; k < 3; k++) begin
      c[k] = cam_l[k] + d * fwd_s[k] + yy * up_s[k] + xx * right_s[k];
      if (c[k] > LaneMax) c[k] = LaneMax;
      else if (c[k] < LaneMin) c[k] = LaneMin;
    end
    send_sphere(c[0], c[1], c[2], r);
  endtask

  task automatic send_noise();
    if ($urandom_range(1)) begin
      send_sphere($signed($urandom), $signed($urandom), $signed($urandom), $urandom & RadMax);
    end else begin
      send_sphere(cam_l[0] + pick(-3000, 3000), cam_l[1] + pick(-3000, 3000),
                  cam_l[2] + pick(-3000, 3000), pick_radius());
    end
  endtask

  task automatic run_random(input int count, input bit shaped);
    int i;
    for (i = 0; i < count; i++) begin
      if (shaped) begin
        calm = (i >= 200 && i < 400);
        if (i == 450) wait_for_results();
      end
      if (aimed && $urandom_range(99) < 80) send_aimed();
      else send_noise();
    end
    calm = 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** frustum_sphere_cull_unit: FAILED **");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    write_enable    = 1'b0;
    register_index  = '0;
    write_data      = '0;
    sphere.valid    = 1'b0;
    sphere.center_x = '0;
    sphere.center_y = '0;
    sphere.center_z = '0;
    sphere.radius   = '0;
    calm            = 1'b0;
    aimed           = 1'b0;
    items_sent      = 0;
    setups          = 1;
    cam_l           = '{0, 0, 0};
    near_l          = fsc_pkg::NearReset;
    far_l           = fsc_pkg::FarReset;
    tan_l           = 0;
    ratio_l         = 0;
    fy_l            = 0;
    fx_l            = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_sphere(0, 0, 0, 5);
    send_sphere(0, 0, 0, 6);
    send_sphere(LaneMax, LaneMin, 0, 0);
    send_sphere(LaneMin, LaneMax, LaneMin, RadMax);

    set_frustum(0, 0, 0, 2, 1, 1, 1, 0, 1, 524288, 64, 64000, 65536, 131072, 65536, 65536);
    send_sphere(0, 0, 6400, 0);
    send_sphere(0, 0, 64, 0);
    send_sphere(0, 0, 63, 0);
    send_sphere(0, 0, 64000, 0);
    send_sphere(0, 0, 64001, 0);
    send_sphere(0, 0, 32, 32);
    send_sphere(0, 0, 31, 32);
    send_sphere(0, 1100, 1000, 100);
    send_sphere(0, 1101, 1000, 100);
    send_sphere(0, -1100, 1000, 100);
    send_sphere(0, -1101, 1000, 100);
    send_sphere(2100, 0, 1000, 100);
    send_sphere(2101, 0, 1000, 100);
    send_sphere(-2100, 0, 1000, 100);
    send_sphere(-2101, 0, 1000, 100);
    send_sphere(LaneMax, LaneMax, LaneMax, RadMax);
    send_sphere(LaneMin, LaneMin, LaneMin, 0);
    send_sphere(LaneMin, LaneMin, LaneMin, RadMax);
    send_sphere(0, 0, 0, RadMax);
    run_random(650, 1'b1);

    set_frustum(-150000, 90000, 40000, 0, -1, 2, 1, 1, 1, 524288,
                32, 200000, 39322, 87381, 76433, 91750);
    run_random(400, 1'b0);

    set_frustum(1000, -2000, 500, 1, 1, 0, -1, 2, 1, 1000000,
                0, RadMax, 262144, RadMax, RadMax, RadMax);
    run_random(300, 1'b0);

    set_frustum(0, 0, 0, 2, -1, 1, 1, 0, -1, 524288, 64000, 64, 0, 0, 0, 0);
    run_random(150, 1'b0);

    load_frustum('1, '1, '1, '1, '1, '1, '1, '1);
    run_random(100, 1'b0);

    load_frustum(pack3(LaneMin, LaneMin, LaneMin), pack3(LaneMin, LaneMin, LaneMin),
                 pack3(LaneMin, LaneMin, LaneMin), pack3(LaneMin, LaneMin, LaneMin),
                 '0, '0, '0, '0);
    run_random(100, 1'b0);

    repeat (2) begin
      load_frustum(word_t'({$urandom, $urandom}), word_t'({$urandom, $urandom}),
                   word_t'({$urandom, $urandom}), word_t'({$urandom, $urandom}),
                   word_t'({$urandom, $urandom}), word_t'({$urandom, $urandom}),
                   word_t'({$urandom, $urandom}), word_t'({$urandom, $urandom}));
      run_random(75, 1'b0);
    end

    wait_for_results();
    $display("sent %0d spheres across %0d frustum setups, reset, extremes and random ones",
             items_sent, setups);
    $display("checked %0d results: %0d culled, %0d kept, %0d mismatches",
             results_seen, culled_seen, results_seen - culled_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("** frustum_sphere_cull_unit: PASSED **");
    end else begin
      $display("** frustum_sphere_cull_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fsc_pkg.sv
src/fsc_if.sv
src/frustum_sphere_cull_unit.sv
dv/frustum_sphere_cull_checker.sv
dv/frustum_sphere_cull_unit_tb.sv
